### sv/cde_pkg.sv
// ---------------------------------------------------------------------------
// cde_pkg
// shared types, field widths and calendar tables for the date evaluator
// ---------------------------------------------------------------------------
package cde_pkg;

    localparam int unsigned DayW   = 5;
    localparam int unsigned MonthW = 4;
    localparam int unsigned YearW  = 14;
    localparam int unsigned LenW   = 5;
    localparam int unsigned DowW   = 3;
    localparam int unsigned DoyW   = 9;

    // month codes
    localparam logic [MonthW-1:0] MonJan = 4'd0;
    localparam logic [MonthW-1:0] MonFeb = 4'd1;
    localparam logic [MonthW-1:0] MonMar = 4'd2;
    localparam logic [MonthW-1:0] MonApr = 4'd3;
    localparam logic [MonthW-1:0] MonMay = 4'd4;
    localparam logic [MonthW-1:0] MonJun = 4'd5;
    localparam logic [MonthW-1:0] MonJul = 4'd6;
    localparam logic [MonthW-1:0] MonAug = 4'd7;
    localparam logic [MonthW-1:0] MonSep = 4'd8;
    localparam logic [MonthW-1:0] MonOct = 4'd9;
    localparam logic [MonthW-1:0] MonNov = 4'd10;
    localparam logic [MonthW-1:0] MonDec = 4'd11;

    localparam logic [LenW-1:0] LeapFebDays = 5'd29;
    localparam logic [DowW-1:0] DowSaturday = 3'd6;

    // floor(y / 100) = (y * YearRecip) >> YearShift for any 14-bit year
    localparam logic [12:0] YearRecip = 13'd5243;
    localparam int unsigned YearShift = 19;
    // floor(s / 7) = (s * WeekRecip) >> WeekShift for the weekday sum range
    localparam logic [7:0]  WeekRecip = 8'd147;
    localparam int unsigned WeekShift = 10;

    // year split handed from the first stage to the second
    typedef struct packed {
        logic       leap;
        logic [6:0] yy;     // year mod 100
        logic [1:0] cent;   // (year mod 400) / 100
    } t_year_info;

    // one result transaction
    typedef struct packed {
        logic            is_leap;
        logic [LenW-1:0] month_length;
        logic [DowW-1:0] day_of_week;
        logic [DoyW-1:0] day_of_year;
        logic            summer_time;
        logic            date_valid;
    } t_date_result;

    function automatic logic [2:0] month_key(input logic [MonthW-1:0] m);
        logic [2:0] k;
        unique case (m)
            MonJan:  k = 3'd1;
            MonFeb:  k = 3'd4;
            MonMar:  k = 3'd4;
            MonApr:  k = 3'd0;
            MonMay:  k = 3'd2;
            MonJun:  k = 3'd5;
            MonJul:  k = 3'd0;
            MonAug:  k = 3'd3;
            MonSep:  k = 3'd6;
            MonOct:  k = 3'd1;
            MonNov:  k = 3'd4;
            MonDec:  k = 3'd6;
            default: k = 3'd0;
        endcase
        return k;
    endfunction

    function automatic logic [2:0] century_key(input logic [1:0] c);
        logic [2:0] k;
        unique case (c)
            2'd0:    k = 3'd6;
            2'd1:    k = 3'd4;
            2'd2:    k = 3'd2;
            default: k = 3'd0;
        endcase
        return k;
    endfunction

    // common-year month lengths, zero for codes past december
    function automatic logic [LenW-1:0] month_days(input logic [MonthW-1:0] m);
        logic [LenW-1:0] n;
        unique case (m) inside
            MonJan, MonMar, MonMay, MonJul, MonAug, MonOct, MonDec: n = 5'd31;
            MonApr, MonJun, MonSep, MonNov:                         n = 5'd30;
            MonFeb:                                                 n = 5'd28;
            default:                                                n = 5'd0;
        endcase
        return n;
    endfunction

    // days ahead of the first of each month in a common year
    function automatic logic [DoyW-1:0] days_before(input logic [MonthW-1:0] m);
        logic [DoyW-1:0] n;
        unique case (m)
            MonJan:  n = 9'd0;
            MonFeb:  n = 9'd31;
            MonMar:  n = 9'd59;
            MonApr:  n = 9'd90;
            MonMay:  n = 9'd120;
            MonJun:  n = 9'd151;
            MonJul:  n = 9'd181;
            MonAug:  n = 9'd212;
            MonSep:  n = 9'd243;
            MonOct:  n = 9'd273;
            MonNov:  n = 9'd304;
            MonDec:  n = 9'd334;
            default: n = 9'd0;
        endcase
        return n;
    endfunction

endpackage

### sv/cde_year.sv
// ---------------------------------------------------------------------------
// cde_year
// splits the year into year-of-century, century index and leap flag
// ---------------------------------------------------------------------------
module cde_year
    import cde_pkg::*;
(
    input  logic [YearW-1:0] i_year,
    output t_year_info       o_info
);

    logic [YearW+12:0] prod;
    logic [7:0]        quot;     // year / 100, at most 163
    logic [YearW-1:0]  hundreds;
    logic [YearW-1:0]  rem;

    always_comb begin
        prod     = (YearW+13)'(i_year) * (YearW+13)'(YearRecip);
        quot     = prod[YearShift+7:YearShift];
        // quot * 100 by shift and add
        hundreds = (YearW'(quot) << 6) + (YearW'(quot) << 5) + (YearW'(quot) << 2);
        rem      = i_year - hundreds;

        o_info.yy   = rem[6:0];
        o_info.cent = quot[1:0];
        // by 4, and not by 100 unless by 400
        o_info.leap = (i_year[1:0] == 2'b00)
                    && ((rem[6:0] != 7'd0) || (quot[1:0] == 2'b00));
    end

endmodule

### sv/cde_eval.sv
// ---------------------------------------------------------------------------
// cde_eval
// month length, weekday, ordinal day and daylight-saving flag of one date
// ---------------------------------------------------------------------------
module cde_eval
    import cde_pkg::*;
(
    input  logic [DayW-1:0]   i_day,
    input  logic [MonthW-1:0] i_month,
    input  t_year_info        i_info,
    output t_date_result      o_res
);

    logic [LenW-1:0] mlen;
    logic            ok;
    logic            jan_fix;
    logic [7:0]      sum;
    logic [15:0]     prod7;
    logic [4:0]      quot7;
    logic [7:0]      rem7;
    logic [DowW-1:0] dow;
    logic [DoyW-1:0] doy;
    logic            summer;

    always_comb begin
        mlen = month_days(i_month);
        if ((i_month == MonFeb) && i_info.leap) begin
            mlen = LeapFebDays;
        end
        ok = (i_month <= MonDec) && (i_day != '0) && (i_day <= mlen);

        // key-value weekday sum, at most 166
        jan_fix = (i_month <= MonFeb) && i_info.leap;
        sum = 8'(i_info.yy[6:2]) + 8'(i_day) + 8'(month_key(i_month))
            + 8'(century_key(i_info.cent)) + 8'(i_info.yy) - 8'(jan_fix);

        prod7 = 16'(sum) * 16'(WeekRecip);
        quot7 = prod7[WeekShift+4:WeekShift];
        rem7  = sum - 8'(11'(quot7) * 11'd7);
        dow   = (rem7[2:0] != 3'd0) ? (rem7[2:0] - 3'd1) : DowSaturday;

        doy = days_before(i_month) + 9'((i_month >= MonMar) && i_info.leap)
            + 9'(i_day) - 9'd1;

        // second sunday of march and first sunday of november rule for the switch months
        case (i_month)
            MonMar:  summer = (6'(i_day) >= (6'(dow) + 6'd8));
            MonNov:  summer = (i_day <= 5'(dow));
            default: summer = (i_month >= MonApr) && (i_month <= MonOct);
        endcase

        o_res.is_leap      = i_info.leap;
        o_res.month_length = mlen;
        o_res.day_of_week  = ok ? dow : '0;
        o_res.day_of_year  = ok ? doy : '0;
        o_res.summer_time  = ok & summer;
        o_res.date_valid   = ok;
    end

endmodule

### sv/calendar_date_evaluator.sv
// ---------------------------------------------------------------------------
// calendar_date_evaluator
// gregorian leap flag, month length, weekday, day of year and summer time
// ---------------------------------------------------------------------------
//
//  channel   handshake              payload
//  -------   --------------------   --------------------------------------
//  date in   i_start / o_busy       i_day, i_month, i_year
//  result    o_result_valid strobe  o_is_leap, o_month_length,
//                                   o_day_of_week, o_day_of_year,
//                                   o_summer_time, o_date_valid
//
//  one transaction per clock cycle; o_busy is always low
//  registers in order: input register, year split register (after the
//  divide-by-100 reciprocal multiply), result register after the weekday,
//  ordinal day and summer time logic
//  synchronous active-low reset clears only the stage valid bits
//  the receiver cannot stall: each result strobes for exactly one cycle
//
module calendar_date_evaluator
    import cde_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  logic [DayW-1:0]   i_day,
    input  logic [MonthW-1:0] i_month,
    input  logic [YearW-1:0]  i_year,
    output logic              o_result_valid,
    output logic              o_is_leap,
    output logic [LenW-1:0]   o_month_length,
    output logic [DowW-1:0]   o_day_of_week,
    output logic [DoyW-1:0]   o_day_of_year,
    output logic              o_summer_time,
    output logic              o_date_valid
);

    // stage 1: captured transaction
    logic              r_s1_valid;
    logic              n_s1_valid;
    logic [DayW-1:0]   r_s1_day;
    logic [MonthW-1:0] r_s1_month;
    logic [YearW-1:0]  r_s1_year;

    // stage 2: year split done
    logic              r_s2_valid;
    logic [DayW-1:0]   r_s2_day;
    logic [MonthW-1:0] r_s2_month;
    t_year_info        r_s2_info;
    t_year_info        n_s2_info;

    // result register
    logic              r_out_valid;
    t_date_result      r_out;
    t_date_result      n_out;

    // every stage moves each cycle, so nothing ever holds the input off
    assign o_busy     = 1'b0;
    assign n_s1_valid = i_start & ~o_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_s2_valid  <= r_s1_valid;
            r_out_valid <= r_s2_valid;
        end
    end

    // payload registers carry no reset
    always_ff @(posedge i_clk) begin
        r_s1_day   <= i_day;
        r_s1_month <= i_month;
        r_s1_year  <= i_year;
        r_s2_day   <= r_s1_day;
        r_s2_month <= r_s1_month;
        r_s2_info  <= n_s2_info;
        r_out      <= n_out;
    end

    // year mod 100, century index and leap test
    cde_year u_year (
        .i_year (r_s1_year),
        .o_info (n_s2_info)
    );

    // per-date tables and weekday arithmetic
    cde_eval u_eval (
        .i_day   (r_s2_day),
        .i_month (r_s2_month),
        .i_info  (r_s2_info),
        .o_res   (n_out)
    );

    assign o_result_valid = r_out_valid;
    assign o_is_leap      = r_out.is_leap;
    assign o_month_length = r_out.month_length;
    assign o_day_of_week  = r_out.day_of_week;
    assign o_day_of_year  = r_out.day_of_year;
    assign o_summer_time  = r_out.summer_time;
    assign o_date_valid   = r_out.date_valid;

endmodule

### tb/calendar_date_evaluator_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// calendar_date_evaluator_tb
// self-checking bench: directed and random dates, each result checked field
// by field against a date predictor, random start gaps on the input side
// ---------------------------------------------------------------------------
module calendar_date_evaluator_tb;
    import cde_pkg::*;

    localparam int unsigned RandomDates = 1500;
    localparam int unsigned MaxGap      = 19;
    localparam int unsigned DrainCycles = 12;   // pipeline is three deep
    localparam int unsigned CycleLimit  = 200000;

    // calendar tables for the predictor
    localparam int unsigned MonthKey [12] = '{1, 4, 4, 0, 2, 5, 0, 3, 6, 1, 4, 6};
    localparam int unsigned CenturyKey [4] = '{6, 4, 2, 0};
    localparam int unsigned MonthDays [12] =
        '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    localparam int unsigned DaysAhead [12] =
        '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

    // one date waiting to be driven, with the idle cycles ahead of it
    typedef struct {
        logic [DayW-1:0]   day;
        logic [MonthW-1:0] month;
        logic [YearW-1:0]  year;
        int unsigned       gap;
    } t_date_item;

    // one accepted date and the result it must produce
    typedef struct {
        logic [DayW-1:0]   day;
        logic [MonthW-1:0] month;
        logic [YearW-1:0]  year;
        t_date_result      res;
    } t_date_check;

    logic              i_clk   = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_start = 1'b0;
    logic [DayW-1:0]   i_day   = '0;
    logic [MonthW-1:0] i_month = '0;
    logic [YearW-1:0]  i_year  = '0;
    logic              o_busy;
    logic              o_result_valid;
    logic              o_is_leap;
    logic [LenW-1:0]   o_month_length;
    logic [DowW-1:0]   o_day_of_week;
    logic [DoyW-1:0]   o_day_of_year;
    logic              o_summer_time;
    logic              o_date_valid;

    t_date_item  pending_dates [$];
    t_date_check due_results [$];

    int unsigned total_dates     = 0;
    int unsigned dates_taken     = 0;
    int unsigned results_checked = 0;
    int unsigned mismatches      = 0;
    int unsigned idle_cycles     = 0;
    int unsigned cycle_count     = 0;
    int unsigned burst_left      = 0;

    calendar_date_evaluator dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .o_busy         (o_busy),
        .i_day          (i_day),
        .i_month        (i_month),
        .i_year         (i_year),
        .o_result_valid (o_result_valid),
        .o_is_leap      (o_is_leap),
        .o_month_length (o_month_length),
        .o_day_of_week  (o_day_of_week),
        .o_day_of_year  (o_day_of_year),
        .o_summer_time  (o_summer_time),
        .o_date_valid   (o_date_valid)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // predictor: leap rule, month length, key-value weekday, ordinal day
    // and the summer time window for one date
    // ------------------------------------------------------------------
    function automatic t_date_result evaluate_date(logic [DayW-1:0] d_in,
                                                   logic [MonthW-1:0] m_in,
                                                   logic [YearW-1:0] y_in);
        t_date_result r;
        int unsigned  d, m, y, mlen, s, w, dow;
        int           prev;
        bit           leap;
        d    = d_in;
        m    = m_in;
        y    = y_in;
        r    = '0;
        leap = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
        r.is_leap = leap;
        // month codes past december leave everything but the leap flag at zero
        if (m_in <= MonDec) begin
            mlen = MonthDays[m];
            if (m_in == MonFeb && leap) mlen = 29;
            r.month_length = LenW'(mlen);
            // day zero or past the month end: weekday, ordinal and summer stay zero
            if (d >= 1 && d <= mlen) begin
                r.date_valid = 1'b1;
                s = (y % 100) / 4 + d + MonthKey[m];
                // january and february step back one only in leap years
                if (m_in <= MonFeb && leap) s = s - 1;
                s = s + CenturyKey[(y % 400) / 100] + y % 100;
                w = s % 7;
                dow = (w > 0) ? w - 1 : 6;
                r.day_of_week = DowW'(dow);
                r.day_of_year = DoyW'(DaysAhead[m] + ((m_in >= MonMar && leap) ? 1 : 0)
                                      + d - 1);
                // day of the most recent sunday decides march and november
                prev = int'(d) - int'(dow);
                if (m_in >= MonApr && m_in <= MonOct) r.summer_time = 1'b1;
                else if (m_in == MonMar && prev >= 8) r.summer_time = 1'b1;
                else if (m_in == MonNov && prev <= 0) r.summer_time = 1'b1;
            end
        end
        return r;
    endfunction

    // gap ahead of the next date: mostly random, now and then a burst of
    // back-to-back transactions
    task automatic queue_date(logic [DayW-1:0] d, logic [MonthW-1:0] m,
                              logic [YearW-1:0] y);
        t_date_item it;
        it.day   = d;
        it.month = m;
        it.year  = y;
        if (burst_left > 0) begin
            it.gap = 0;
            burst_left--;
        end else begin
            it.gap = $urandom_range(0, MaxGap);
            if ($urandom_range(0, 39) == 0) burst_left = $urandom_range(10, 40);
        end
        pending_dates.push_back(it);
    endtask

    task automatic report(string msg);
        if (mismatches < 100) $display("ERROR @%0t: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want,
                               t_date_check e);
        if (got !== want)
            report($sformatf("%s got %0d expected %0d for day %0d month %0d year %0d",
                             name, got, want, e.day, e.month, e.year));
    endtask

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial begin
        logic [DayW-1:0]   d;
        logic [MonthW-1:0] m;
        logic [YearW-1:0]  y;
        t_date_result      probe;

        // directed: year and day extremes, leap rules, invalid days and
        // months, summer time edges in march and november
        queue_date(5'd1,  MonJan, 14'd0);
        queue_date(5'd31, MonDec, 14'd9999);
        queue_date(5'd0,  MonJan, 14'd2023);
        queue_date(5'd31, MonApr, 14'd2023);
        queue_date(5'd29, MonFeb, 14'd2000);
        queue_date(5'd29, MonFeb, 14'd1900);
        queue_date(5'd29, MonFeb, 14'd2024);
        queue_date(5'd28, MonFeb, 14'd2023);
        queue_date(5'd30, MonFeb, 14'd2024);
        for (int k = 1; k <= 4; k++) queue_date(5'd31, MonthW'(MonDec + k), 14'd16383);
        queue_date(5'd1,  MonMar, 14'd2024);
        queue_date(5'd7,  MonMar, 14'd2024);
        queue_date(5'd8,  MonMar, 14'd2024);
        queue_date(5'd31, MonMar, 14'd2024);
        queue_date(5'd1,  MonNov, 14'd2024);
        queue_date(5'd3,  MonNov, 14'd2024);
        queue_date(5'd4,  MonNov, 14'd2024);
        queue_date(5'd30, MonNov, 14'd2024);
        queue_date(5'd31, MonOct, 14'd2023);
        queue_date(5'd31, MonJul, 14'd1600);
        queue_date(5'd1,  MonMay, 14'd100);
        queue_date(5'd31, MonDec, 14'd16383);

        // random: mostly well-formed dates, some just past the month end,
        // the rest raw noise over the full field widths
        for (int n = 0; n < RandomDates; n++) begin
            case ($urandom_range(0, 9))
                0:       y = YearW'($urandom_range(0, 163) * 100);
                1:       y = YearW'($urandom_range(10000, 16383));
                default: y = YearW'($urandom_range(0, 9999));
            endcase
            if ($urandom_range(0, 2) == 0) begin
                case ($urandom_range(0, 2))
                    0:       m = MonFeb;
                    1:       m = MonMar;
                    default: m = MonNov;
                endcase
            end else begin
                m = MonthW'($urandom_range(MonJan, MonDec));
            end
            probe = evaluate_date(5'd1, m, y);
            case ($urandom_range(0, 19))
                0, 1, 2: begin
                    d = DayW'($urandom);
                    m = MonthW'($urandom);
                    y = YearW'($urandom);
                end
                3:       d = probe.month_length + 5'd1;
                default: d = DayW'($urandom_range(1, probe.month_length));
            endcase
            queue_date(d, m, y);
        end
        total_dates = pending_dates.size();

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (dates_taken == total_dates);
        wait (results_checked == total_dates);
        repeat (DrainCycles) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("calendar_date_evaluator_tb passed");
        end else begin
            $display("calendar_date_evaluator_tb failed");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // driver: a transaction completes on an edge with start high and busy
    // low; the next date goes out once its gap has passed, junk otherwise
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_date_item  nxt;
        t_date_check taken;
        if (!i_rst_n) begin
            i_start <= 1'b0;
        end else begin
            if (i_start && !o_busy) begin
                taken.day   = i_day;
                taken.month = i_month;
                taken.year  = i_year;
                taken.res   = evaluate_date(i_day, i_month, i_year);
                due_results.push_back(taken);
                dates_taken++;
            end
            // hold the current date while busy, otherwise move on
            if (!i_start || !o_busy) begin
                if (pending_dates.size() != 0 && idle_cycles >= pending_dates[0].gap) begin
                    nxt = pending_dates.pop_front();
                    i_start     <= 1'b1;
                    i_day       <= nxt.day;
                    i_month     <= nxt.month;
                    i_year      <= nxt.year;
                    idle_cycles <= 0;
                end else begin
                    i_start     <= 1'b0;
                    i_day       <= DayW'($urandom);
                    i_month     <= MonthW'($urandom);
                    i_year      <= YearW'($urandom);
                    idle_cycles <= idle_cycles + 1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: each strobed result is matched against the oldest date
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_date_check e;
        if (i_rst_n && o_result_valid === 1'b1) begin
            if (due_results.size() == 0) begin
                report("result strobe with no date outstanding");
            end else begin
                e = due_results.pop_front();
                check_field("is_leap",      o_is_leap,      e.res.is_leap,      e);
                check_field("month_length", o_month_length, e.res.month_length, e);
                check_field("day_of_week",  o_day_of_week,  e.res.day_of_week,  e);
                check_field("day_of_year",  o_day_of_year,  e.res.day_of_year,  e);
                check_field("summer_time",  o_summer_time,  e.res.summer_time,  e);
                check_field("date_valid",   o_date_valid,   e.res.date_valid,   e);
                results_checked++;
            end
        end
    end

    // watchdog: the slowest run stays well under this limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("calendar_date_evaluator_tb failed");
            $finish;
        end
    end

endmodule
